@@ rtl/chse_pkg.sv @@
// chse_pkg: shared types and constants of the chebyshev series evaluator
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package chse_pkg;

    // signed q16.16 words, q10.30 chebyshev terms, exact q16.16 running sum
    typedef logic signed [31:0] t_word;
    typedef logic signed [40:0] t_tval;
    typedef logic signed [47:0] t_acc;

    localparam int NCOEF  = 6;
    localparam int QBITS  = 31;   // quotient bits of u, one per divider stage
    localparam int QDEPTH = 4;
    localparam int QPTR   = $clog2(QDEPTH);

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
    localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
    localparam logic [2:0] REG_COEF_0     = 3'd2;

    localparam t_word RESET_LOW  = -32'sd65536;
    localparam t_word RESET_HIGH = 32'sd65536;

    localparam t_word U_POS_MAX = 32'sh7FFFFFFF;
    localparam t_word U_NEG_MAX = 32'sh80000000;
    localparam t_tval ONE_Q30   = 41'sh40000000;
    localparam t_tval T_MAX     = 41'sh0FFFFFFFFFF;
    localparam t_tval T_MIN     = 41'sh10000000000;
    localparam t_acc  SUM_MAX   = 48'sh00007FFFFFFF;
    localparam t_acc  SUM_MIN   = 48'shFFFF80000000;

    // classified item handed from front to back
    typedef struct packed {
        logic        fault;
        logic        sat;
        logic        neg;
        logic        clamp;
        t_word       u_clamp;
        logic [32:0] mag;
        logic [31:0] den;
    } t_front_item;

    // context travelling through the term stages
    typedef struct packed {
        logic  fault;
        logic  sat;
        t_word u;
        t_tval t_prev;
        t_tval t_cur;
        t_acc  sum;
    } t_term;

    typedef t_word t_coef_arr [NCOEF];

endpackage

`default_nettype wire

@@ rtl/chse_if.sv @@
// chse_in_if and chse_out_if: valid/ready channels of the evaluator
// depends on chse_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none

interface chse_in_if;
    import chse_pkg::*;
    logic  valid;
    logic  ready;
    t_word x_value;
    modport source (output valid, output x_value, input ready);
    modport sink (input valid, input x_value, output ready);
endinterface

interface chse_out_if;
    import chse_pkg::*;
    logic  valid;
    logic  ready;
    t_word series_value;
    logic  saturated;
    logic  range_fault;
    modport source (output valid, output series_value, output saturated,
                    output range_fault, input ready);
    modport sink (input valid, input series_value, input saturated,
                  input range_fault, output ready);
endinterface

`default_nettype wire

@@ rtl/chebyshev_series_eval.sv @@
// chebyshev_series_eval: top level, config registers, front, queue and back
// depends on chse_pkg, chse_if, chse_front, chse_queue, chse_back
//
// usage
//  - i_in carries one sample x_value (signed q16.16) per item, o_out one result
//    per item: series_value (signed q16.16), saturated, range_fault
//  - the apb port holds range_low, range_high and coef_0..coef_5 at byte
//    addresses 0, 4, .. 28; write only while no item is in flight
//  - from input accept to output valid an item passes the front register,
//    queue, 31 divider stages (one quotient bit of u per stage), u stage,
//    two stages per term and the output reg
//  - throughput is one item per cycle unless the receiver stalls; the
//    divider and term multipliers are pipelined like every other stage
//  - reset empties the front, queue and pipeline and loads the interval
//    [-1, 1] with all coefficients zero
//  - when the receiver stalls, the back pipeline holds in place, the queue
//    fills, and then the input channel drops ready; nothing is lost
`timescale 1ns / 1ps
`default_nettype none

module chebyshev_series_eval
    import chse_pkg::*;
#(
    parameter int TERMS = 6
)
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    chse_in_if.sink     i_in,
    chse_out_if.source  o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    t_word       r_low;
    t_word       r_high;
    t_coef_arr   r_coef;
    logic [2:0]  w_idx;
    logic        w_wr;

    // front to queue to back
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_q_valid;
    t_front_item w_f_item;
    t_front_item w_q_item;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= RESET_LOW;
            r_high <= RESET_HIGH;
            for (int i = 0; i < NCOEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RANGE_LOW:  r_low  <= pwdata;
                REG_RANGE_HIGH: r_high <= pwdata;
                default:        r_coef[3'(w_idx - REG_COEF_0)] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RANGE_LOW:  prdata = r_low;
            REG_RANGE_HIGH: prdata = r_high;
            default:        prdata = r_coef[3'(w_idx - REG_COEF_0)];
        endcase
    end

    // front: map and classify each sample
    chse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in),
        .i_low   (r_low),
        .i_high  (r_high),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_f_item)
    );

    // queue lets the front keep accepting while the back is stalled
    chse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_f_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_q_item)
    );

    // back: divider, recurrence and sum
    chse_back #(
        .TERMS (TERMS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .i_coef    (r_coef),
        .o_out_ch  (o_out)
    );

    // an empty interval always reports a clean zero
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.range_fault |-> (o_out.series_value == '0) && !o_out.saturated)
        else $error("range fault result not zero");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // the queue never pops while empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ rtl/chse_front.sv @@
// chse_front: accepts samples, maps them onto the interval and classifies
// depends on chse_pkg and chse_in_if
`timescale 1ns / 1ps
`default_nettype none

module chse_front
    import chse_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    chse_in_if.sink     i_in_ch,
    input  t_word       i_low,
    input  t_word       i_high,
    input  wire         i_full,
    output logic        o_push,
    output t_front_item o_item
);

    logic              r_valid;
    t_front_item       r_item;
    t_front_item       n_item;
    logic signed [34:0] w_num;
    logic signed [34:0] w_two_den;
    logic signed [34:0] w_abs;
    logic signed [32:0] w_den;

    assign o_push        = r_valid && !i_full;
    assign i_in_ch.ready = !r_valid || !i_full;
    assign o_item        = r_item;

    always_comb begin
        w_num     = 35'(i_in_ch.x_value) + 35'(i_in_ch.x_value) - 35'(i_low) - 35'(i_high);
        w_den     = 33'(i_high) - 33'(i_low);
        w_two_den = 35'(w_den) + 35'(w_den);
        w_abs     = w_num[34] ? -w_num : w_num;
        n_item.fault   = w_den[32] || (w_den == '0);
        n_item.sat     = 1'b0;
        n_item.neg     = w_num[34];
        n_item.clamp   = 1'b1;
        n_item.u_clamp = '0;
        n_item.mag     = '0;
        n_item.den     = w_den[31:0];
        if (n_item.fault) begin
            n_item.clamp = 1'b1;
        end else if (w_num >= w_two_den) begin
            n_item.u_clamp = U_POS_MAX;
            n_item.sat     = 1'b1;
        end else if (w_num < -w_two_den) begin
            n_item.u_clamp = U_NEG_MAX;
            n_item.sat     = 1'b1;
        end else if (w_num == -w_two_den) begin
            // exactly -2 is representable
            n_item.u_clamp = U_NEG_MAX;
        end else begin
            n_item.clamp = 1'b0;
            n_item.mag   = w_abs[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/chse_queue.sv @@
// chse_queue: short fifo of classified items between front and back
// depends on chse_pkg
`timescale 1ns / 1ps
`default_nettype none

module chse_queue
    import chse_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  t_front_item i_wdata,
    output logic        o_full,
    input  wire         i_pop,
    output logic        o_valid,
    output t_front_item o_rdata
);

    t_front_item     r_mem [QDEPTH];
    logic [QPTR-1:0] r_wr;
    logic [QPTR-1:0] r_rd;
    logic [QPTR:0]   r_count;

    assign o_full  = (r_count == (QPTR+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/chse_term.sv @@
// chse_term: one chebyshev term, two stages (split products, then add and clamp)
// depends on chse_pkg
`timescale 1ns / 1ps
`default_nettype none

module chse_term
    import chse_pkg::*;
#(
    parameter bit CHECK_T = 1'b1
)
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_en,
    input  wire   i_valid,
    input  t_term i_s,
    input  t_word i_coef,
    output logic  o_valid,
    output t_term o_s
);

    logic        r_a_valid;
    t_term       r_a;
    logic        r_negc;
    logic        r_negu;
    logic [42:0] r_pch;
    logic [61:0] r_pcl;
    logic [42:0] r_puh;
    logic [61:0] r_pul;
    logic        r_b_valid;
    t_term       r_b;

    logic [31:0]        w_mag_c;
    logic [31:0]        w_mag_u;
    logic [40:0]        w_mag_t;
    logic [42:0]        w_mc;
    logic [42:0]        w_mu;
    logic signed [43:0] w_sc;
    logic signed [43:0] w_su;
    logic signed [45:0] w_traw;
    t_tval              w_tnext;
    logic               w_tclamp;

    // magnitudes, products truncate toward zero on the magnitude
    always_comb begin
        w_mag_c = i_coef[31] ? 32'(-i_coef) : 32'(i_coef);
        w_mag_u = i_s.u[31] ? 32'(-i_s.u) : 32'(i_s.u);
        w_mag_t = i_s.t_cur[40] ? 41'(-i_s.t_cur) : 41'(i_s.t_cur);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= i_s;
            r_negc <= i_coef[31] ^ i_s.t_cur[40];
            r_negu <= i_s.u[31] ^ i_s.t_cur[40];
            r_pch  <= w_mag_c * w_mag_t[40:30];
            r_pcl  <= w_mag_c * w_mag_t[29:0];
            r_puh  <= w_mag_u * w_mag_t[40:30];
            r_pul  <= w_mag_u * w_mag_t[29:0];
        end
    end

    always_comb begin
        w_mc   = r_pch + 43'(r_pcl[61:30]);
        w_mu   = r_puh + 43'(r_pul[61:30]);
        w_sc   = r_negc ? -$signed({1'b0, w_mc}) : $signed({1'b0, w_mc});
        w_su   = r_negu ? -$signed({1'b0, w_mu}) : $signed({1'b0, w_mu});
        w_traw = 46'(w_su) + 46'(w_su) - 46'(r_a.t_prev);
        w_tclamp = 1'b1;
        if (w_traw > 46'(T_MAX)) begin
            w_tnext = T_MAX;
        end else if (w_traw < 46'(T_MIN)) begin
            w_tnext = T_MIN;
        end else begin
            w_tnext  = w_traw[40:0];
            w_tclamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b.fault  <= r_a.fault;
            r_b.sat    <= r_a.sat | (CHECK_T & w_tclamp);
            r_b.u      <= r_a.u;
            r_b.t_prev <= r_a.t_cur;
            r_b.t_cur  <= w_tnext;
            r_b.sum    <= r_a.sum + 48'(w_sc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    assign o_valid = r_b_valid;
    assign o_s     = r_b;

endmodule

`default_nettype wire

@@ rtl/chse_back.sv @@
// chse_back: pipelined divider for u, term stages, output saturation register
// depends on chse_pkg, chse_out_if and chse_term
`timescale 1ns / 1ps
`default_nettype none

module chse_back
    import chse_pkg::*;
#(
    parameter int TERMS = 6
)
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_valid,
    input  t_front_item i_q_item,
    output logic        o_pop,
    input  t_coef_arr   i_coef,
    chse_out_if.source  o_out_ch
);

    typedef struct packed {
        logic        fault;
        logic        sat;
        logic        neg;
        logic        clamp;
        t_word       u_clamp;
        logic [31:0] den;
    } t_div_meta;

    logic        w_en;
    logic        r_dv [QBITS];
    logic [31:0] r_rem [QBITS];
    logic [30:0] r_q [QBITS];
    t_div_meta   r_dm [QBITS];

    logic  r_s0_valid;
    t_term r_s0;
    t_term n_s0;
    logic  w_sv [TERMS];
    t_term w_s [TERMS];

    logic  r_out_valid;
    t_word r_value;
    logic  r_sat;
    logic  r_fault;

    // whole back pipeline advances together
    assign w_en  = !r_out_valid || o_out_ch.ready;
    assign o_pop = w_en && i_q_valid;

    for (genvar d = 0; d < QBITS; d++) begin : g_div
        logic [32:0] w_din;
        logic [30:0] w_qin;
        t_div_meta   w_min;
        logic        w_vin;
        logic        w_ge;
        logic [32:0] w_diff;
        if (d == 0) begin : g_first
            assign w_din = i_q_item.mag;
            assign w_qin = '0;
            assign w_vin = i_q_valid;
            assign w_min = '{fault: i_q_item.fault, sat: i_q_item.sat,
                             neg: i_q_item.neg, clamp: i_q_item.clamp,
                             u_clamp: i_q_item.u_clamp, den: i_q_item.den};
        end else begin : g_next
            assign w_din = {r_rem[d-1], 1'b0};
            assign w_qin = r_q[d-1];
            assign w_vin = r_dv[d-1];
            assign w_min = r_dm[d-1];
        end
        assign w_ge   = (w_din >= {1'b0, w_min.den});
        assign w_diff = w_din - {1'b0, w_min.den};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[d] <= w_ge ? w_diff[31:0] : w_din[31:0];
                r_q[d]   <= {w_qin[29:0], w_ge};
                r_dm[d]  <= w_min;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[d] <= 1'b0;
            end else if (w_en) begin
                r_dv[d] <= w_vin;
            end
        end
    end

    // signed u, first two terms, constant coefficient
    always_comb begin
        n_s0.fault  = r_dm[QBITS-1].fault;
        n_s0.sat    = r_dm[QBITS-1].sat;
        if (r_dm[QBITS-1].clamp) begin
            n_s0.u = r_dm[QBITS-1].u_clamp;
        end else if (r_dm[QBITS-1].neg) begin
            n_s0.u = -$signed({1'b0, r_q[QBITS-1]});
        end else begin
            n_s0.u = $signed({1'b0, r_q[QBITS-1]});
        end
        n_s0.t_prev = ONE_Q30;
        n_s0.t_cur  = 41'(n_s0.u);
        n_s0.sum    = 48'(i_coef[0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= r_dv[QBITS-1];
        end
    end

    assign w_s[0]  = r_s0;
    assign w_sv[0] = r_s0_valid;

    for (genvar k = 1; k < TERMS; k++) begin : g_term
        chse_term #(
            .CHECK_T (k + 1 < TERMS)
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[k-1]),
            .i_s     (w_s[k-1]),
            .i_coef  (i_coef[k]),
            .o_valid (w_sv[k]),
            .o_s     (w_s[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fault <= w_s[TERMS-1].fault;
            if (w_s[TERMS-1].fault) begin
                r_value <= '0;
                r_sat   <= 1'b0;
            end else if (w_s[TERMS-1].sum > SUM_MAX) begin
                r_value <= U_POS_MAX;
                r_sat   <= 1'b1;
            end else if (w_s[TERMS-1].sum < SUM_MIN) begin
                r_value <= U_NEG_MAX;
                r_sat   <= 1'b1;
            end else begin
                r_value <= w_s[TERMS-1].sum[31:0];
                r_sat   <= w_s[TERMS-1].sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_sv[TERMS-1];
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.series_value = r_value;
    assign o_out_ch.saturated    = r_sat;
    assign o_out_ch.range_fault  = r_fault;

endmodule

`default_nettype wire

@@ sim/chse_checker.sv @@
// chse_checker: watches the apb port and both channels of the chebyshev evaluator
// predicts every result from its own copy of the registers; depends on chse_pkg, chse_if
`timescale 1ns / 1ps

module chse_checker
    import chse_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    chse_in_if         mon_in,
    chse_out_if        mon_out,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire  [4:0] paddr,
    input  wire [31:0] pwdata,
    input  wire        pready,
    output int         o_errors,
    output int         o_pending,
    output logic       o_moved
);

    typedef struct {
        logic [31:0] value;
        logic        sat;
        logic        fault;
    } t_series_res;

    longint     lo_q16, hi_q16;
    longint     coefs [NCOEF];
    t_series_res series_q [$];

    // (a*b) >> 30 rounded toward zero
    function automatic longint mulq30(longint a, longint b);
        bit          neg;
        bit [63:0]   ma, mb, r;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        r   = ma * (mb >> 30) + ((ma * (mb & 64'h3FFFFFFF)) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_series_res eval_series(logic signed [31:0] x);
        t_series_res r;
        longint      num, den, u, tp, tc, tn, sum;
        bit [63:0]   mag, q;
        bit          sat;
        r.fault = 0;
        sat     = 0;
        if (hi_q16 <= lo_q16) begin
            r.value = 0;
            r.sat   = 0;
            r.fault = 1;
            return r;
        end
        num = 2 * longint'(x) - lo_q16 - hi_q16;
        den = hi_q16 - lo_q16;
        if (num >= 2 * den) begin
            u   = 64'sh7FFFFFFF;
            sat = 1;
        end else if (num < -2 * den) begin
            u   = -(64'sd1 <<< 31);
            sat = 1;
        end else if (num == -2 * den) begin
            u = -(64'sd1 <<< 31);
        end else begin
            mag = (num < 0) ? -num : num;
            q   = (mag << 30) / den;
            u   = (num < 0) ? -longint'(q) : longint'(q);
        end
        tp  = 64'sd1 <<< 30;
        tc  = u;
        sum = coefs[0];
        for (int k = 1; k < NCOEF; k++) begin
            sum += mulq30(coefs[k], tc);
            tn = 2 * mulq30(u, tc) - tp;
            // term clamp to q10.30, flagged only if the term is used later
            if (tn > (64'sd1 <<< 40) - 1) begin
                tn = (64'sd1 <<< 40) - 1;
                if (k + 1 < NCOEF) sat = 1;
            end else if (tn < -(64'sd1 <<< 40)) begin
                tn = -(64'sd1 <<< 40);
                if (k + 1 < NCOEF) sat = 1;
            end
            tp = tc;
            tc = tn;
        end
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            sat = 1;
        end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            sat = 1;
        end
        r.value = sum[31:0];
        r.sat   = sat;
        return r;
    endfunction

    assign o_pending = series_q.size();

    // sampled 1 ns ahead of each rising edge, when every input has settled
    initial begin
        t_series_res exp_r;
        o_errors = 0;
        o_moved  = 0;
        lo_q16   = -65536;
        hi_q16   = 65536;
        foreach (coefs[i]) coefs[i] = 0;
        forever begin
            @(negedge i_clk);
            #5;
            o_moved = 0;
            if (i_rst_n) begin
                if (psel && penable && pwrite && pready) begin
                    case (paddr[4:2])
                        REG_RANGE_LOW:  lo_q16 = longint'($signed(pwdata));
                        REG_RANGE_HIGH: hi_q16 = longint'($signed(pwdata));
                        default:        coefs[paddr[4:2] - REG_COEF_0] =
                                            longint'($signed(pwdata));
                    endcase
                end
                if (mon_in.valid && mon_in.ready) begin
                    series_q.push_back(eval_series(mon_in.x_value));
                    o_moved = 1;
                end
                if (mon_out.valid && mon_out.ready) begin
                    o_moved = 1;
                    if (series_q.size() == 0) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("unexpected result item value=%h", mon_out.series_value);
                    end else begin
                        exp_r = series_q.pop_front();
                        if (mon_out.series_value !== exp_r.value ||
                            mon_out.saturated !== exp_r.sat ||
                            mon_out.range_fault !== exp_r.fault) begin
                            o_errors++;
                            if (o_errors <= 10)
                                $display("mismatch: exp %h sat %b flt %b, got %h sat %b flt %b",
                                         exp_r.value, exp_r.sat, exp_r.fault,
                                         mon_out.series_value, mon_out.saturated,
                                         mon_out.range_fault);
                        end
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb.sv @@
// tb: stimulus and verdict for chebyshev_series_eval
// depends on chse_pkg, chse_if, chse_checker and the block itself
`timescale 1ns / 1ps

module tb;
    import chse_pkg::*;

    localparam int STALL_LIMIT = 5000;   // cycles with no item moving
    localparam int DRAIN_WAIT  = 120;    // well past the time an item takes through the pipeline

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    logic        moved;

    int send_pct, recv_pct;
    int hold_left;
    int stall_cnt;

    chse_in_if  in_ch ();
    chse_out_if out_ch ();

    chebyshev_series_eval u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    chse_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .mon_in    (in_ch),
        .mon_out   (out_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_moved   (moved)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random ready, with one long hold-off to fill the block
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // watchdog on cycles in which no item moves on either channel
    initial begin
        stall_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (moved) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // apb write: setup cycle then access cycle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic load_setting(logic [31:0] lo, logic [31:0] hi, logic [31:0] c [NCOEF]);
        reg_write(REG_RANGE_LOW, lo);
        reg_write(REG_RANGE_HIGH, hi);
        for (int i = 0; i < NCOEF; i++)
            reg_write(REG_COEF_0 + 3'(i), c[i]);
    endtask

    // offer one sample, with random gaps, until the block takes it
    task automatic send_item(logic [31:0] x);
        while ($urandom_range(99) < send_pct) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1;
        in_ch.x_value <= x;
        forever begin
            #5;
            if (in_ch.ready) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // let everything drain before touching the registers
    task automatic drain();
        in_ch.valid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // sample drawn mostly inside the current interval, sometimes near or far out
    function automatic logic [31:0] pick_x(longint lo, longint hi);
        longint span, x;
        int     sel;
        sel  = $urandom_range(9);
        span = hi - lo;
        if (span <= 0 || sel >= 8) return $urandom;
        if (sel >= 6) x = lo - span + longint'($urandom) % (3 * span + 1);
        else x = lo + longint'({$urandom, $urandom} & 64'h7FFFFFFFFFFF) % (span + 1);
        if (x > 64'sd2147483647) x = 64'sd2147483647;
        if (x < -64'sd2147483648) x = -64'sd2147483648;
        return x[31:0];
    endfunction

    initial begin
        logic [31:0] cf [NCOEF];
        logic [31:0] lo, hi;
        int          sent;
        int          nphase;

        i_rst_n       = 0;
        psel          = 0;
        penable       = 0;
        pwrite        = 0;
        paddr         = 0;
        pwdata        = 0;
        in_ch.valid   = 0;
        in_ch.x_value = 0;
        send_pct      = 13;
        recv_pct      = 72;
        hold_left     = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // reset setting: all coefficients zero
        send_item(32'h0);
        send_item(32'h7FFFFFFF);
        send_item(32'h80000000);
        drain();

        // unit interval, unit coefficients, edges and points outside
        foreach (cf[i]) cf[i] = 32'h00010000;
        load_setting(32'hFFFF0000, 32'h00010000, cf);
        send_item(32'hFFFF0000);
        send_item(32'h00010000);
        send_item(32'h00000000);
        send_item(32'h00008000);
        send_item(32'hFFFD0000);          // u is -3, below -2, clamped
        send_item(32'h00030000);          // u would be 3, clamped
        send_item(32'hFFFCFFFF);          // u below -2, clamped
        drain();

        // widest interval, largest coefficients: sum overflow
        foreach (cf[i]) cf[i] = 32'h7FFFFFFF;
        load_setting(32'h80000000, 32'h7FFFFFFF, cf);
        send_item(32'h7FFFFFFF);
        send_item(32'h80000000);
        send_item(32'h00000000);
        drain();

        // most negative coefficients on a narrow interval: term overflow
        foreach (cf[i]) cf[i] = 32'h80000000;
        load_setting(32'h00000000, 32'h00000001, cf);
        send_item(32'h7FFFFFFF);
        send_item(32'h80000000);
        send_item(32'h00000001);
        drain();

        // empty intervals: equal ends, then reversed
        load_setting(32'h00010000, 32'h00010000, cf);
        send_item(32'h00010000);
        send_item(32'h12345678);
        drain();
        load_setting(32'h7FFFFFFF, 32'h80000000, cf);
        send_item(32'h00000000);
        send_item(32'hFFFFFFFF);
        drain();

        // random settings; idle modes move on by thirds of the run
        sent   = 0;
        nphase = 0;
        while (sent < 700) begin
            if (sent < 233) begin
                send_pct = 13;
                recv_pct = 72;
            end else if (sent < 466) begin
                send_pct = 72;
                recv_pct = 13;
            end else begin
                send_pct = 0;
                recv_pct = 0;
            end
            case ($urandom_range(3))
                0: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                1: begin
                    lo = 32'(-$urandom_range(32'h40000));
                    hi = 32'($urandom_range(32'h40000));
                end
                default: begin
                    lo = 32'(-$urandom_range(32'h20000, 32'h1000));
                    hi = lo + 32'($urandom_range(32'h40000, 32'h100));
                end
            endcase
            foreach (cf[i])
                cf[i] = ($urandom_range(3) == 0) ? $urandom
                                                 : 32'($signed($urandom) >>> 12);
            load_setting(lo, hi, cf);
            for (int n = 0; n < 60; n++) begin
                // long receiver hold-off once the input is running flat out
                if (nphase == 9 && n == 5) hold_left = 400;
                send_item(pick_x($signed(lo), $signed(hi)));
                sent++;
            end
            drain();
            nphase++;
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
